/* hdl/double_ended_queue_with_search_macros.svh */
// Assertion macros used by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define DEQS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define DEQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DEQS_ASSERT_NOW(lbl, ante, cons, msg)
`define DEQS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/deqs_pkg.sv */
// Package with types and constants of the double-ended queue with search.
package deqs_pkg;

  // Default number of entries in the element store.
  localparam int DEPTH_DEF = 16;

  // Width of one stored element.
  localparam int ELEM_W = 32;

  // Action codes of an input item.
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_SEARCH     = 3'd4
  } action_t;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_SEARCH,
    ST_RESULT
  } state_t;

  // Input item.
  typedef struct packed {
    logic [2:0]               action;
    logic signed [ELEM_W-1:0] value;
  } deqs_in_t;

  // Result item.
  typedef struct packed {
    status_t                  status;
    logic signed [ELEM_W-1:0] data;
    logic [4:0]               position;
    logic [4:0]               count;
  } deqs_out_t;

endpackage

/* hdl/deqs_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module deqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/double_ended_queue_with_search.sv */
// Top level of the bounded double-ended queue with linear search.
//
// Input channel in_valid/in_ready/in_data carries one item: an action
// (push front, push back, pop front, pop back, search) and a 32-bit value.
// Every accepted item yields exactly one result item on out_valid/
// out_ready/out_data: status, popped data, 1-based match position, count.
// The block handles one item at a time; in_ready is high only while the
// sequencer is idle. Each item passes through the execute and result states;
// a pop of a non-empty queue also passes the pop state, and a search walks
// the store from the front until the first match or the end of the entries.
// The search runs one shared address adder and one comparator over the
// store, one entry per cycle, fed by the single read port of the RAM.
// The result sits in an output register; if the receiver stalls, the next
// item is still accepted and its result waits in the sequencer until the
// output register frees up. Synchronous active-low reset empties the queue
// and sets the front pointer to zero; no clearing pass of the store runs.
`include "double_ended_queue_with_search_macros.svh"

module double_ended_queue_with_search #(
  parameter int DEPTH = deqs_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  deqs_pkg::deqs_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output deqs_pkg::deqs_out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] OCC_FULL = CW'(DEPTH);
  localparam logic [AW:0]   SUM_WRAP = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] OFS_BACK_STEP = AW'(DEPTH - 1);
  localparam logic [AW-1:0] OFS_ONE = AW'(1);

  deqs_pkg::state_t state_r, state_nxt;

  // Queue state.
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] occ_r, occ_nxt;

  // Latched item and search index.
  logic [2:0]                         act_r;
  logic signed [deqs_pkg::ELEM_W-1:0] key_r;
  logic [CW-1:0]                      idx_r, idx_nxt;

  // Pending result fields.
  deqs_pkg::status_t                  res_status_r, res_status_nxt;
  logic signed [deqs_pkg::ELEM_W-1:0] res_data_r, res_data_nxt;
  logic [4:0]                         res_pos_r, res_pos_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  deqs_pkg::deqs_out_t out_r, out_nxt;

  // Store access.
  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  logic [deqs_pkg::ELEM_W-1:0] ram_rdata;

  // Shared address unit.
  logic [AW-1:0] ofs;
  logic [AW:0]   slot_sum;
  logic [AW-1:0] slot;

  logic full, empty, hit, in_fire, out_free;

  assign full     = (occ_r == OCC_FULL);
  assign empty    = (occ_r == '0);
  assign in_ready = (state_r == deqs_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign hit      = ($signed(ram_rdata) == key_r);

  // Circular slot: front plus offset, wrapped once at the store depth.
  assign slot_sum = {1'b0, front_r} + {1'b0, ofs};
  assign slot     = (slot_sum >= SUM_WRAP) ? AW'(slot_sum - SUM_WRAP) : AW'(slot_sum);
  assign ram_addr = slot;

  // Offset selection for the shared address unit.
  always_comb begin
    ofs = '0;
    if (state_r == deqs_pkg::ST_SEARCH) begin
      ofs = AW'(idx_r);
    end else if (state_r == deqs_pkg::ST_POP) begin
      ofs = OFS_ONE;
    end else begin
      unique case (act_r)
        deqs_pkg::ACT_PUSH_FRONT: ofs = OFS_BACK_STEP;
        deqs_pkg::ACT_PUSH_BACK:  ofs = AW'(occ_r);
        deqs_pkg::ACT_POP_BACK:   ofs = AW'(occ_r - 1'b1);
        default:                  ofs = '0;
      endcase
    end
  end

  deqs_ram #(
    .WIDTH (deqs_pkg::ELEM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (key_r),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      deqs_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = deqs_pkg::ST_EXEC;
        end
      end
      deqs_pkg::ST_EXEC: begin
        unique case (act_r)
          deqs_pkg::ACT_POP_FRONT,
          deqs_pkg::ACT_POP_BACK:  state_nxt = empty ? deqs_pkg::ST_RESULT
                                                     : deqs_pkg::ST_POP;
          deqs_pkg::ACT_SEARCH:    state_nxt = deqs_pkg::ST_SEARCH;
          default:                 state_nxt = deqs_pkg::ST_RESULT;
        endcase
      end
      deqs_pkg::ST_POP: state_nxt = deqs_pkg::ST_RESULT;
      deqs_pkg::ST_SEARCH: begin
        // A read is pending whenever the index is above zero.
        if ((idx_r != '0 && hit) || idx_r >= occ_r) begin
          state_nxt = deqs_pkg::ST_RESULT;
        end
      end
      deqs_pkg::ST_RESULT: begin
        if (out_free) begin
          state_nxt = deqs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = deqs_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    front_nxt      = front_r;
    occ_nxt        = occ_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    unique case (state_r)
      deqs_pkg::ST_EXEC: begin
        res_status_nxt = deqs_pkg::STS_OK;
        res_data_nxt   = '0;
        res_pos_nxt    = '0;
        idx_nxt        = '0;
        unique case (act_r)
          deqs_pkg::ACT_PUSH_FRONT: begin
            if (full) begin
              res_status_nxt = deqs_pkg::STS_FULL;
            end else begin
              ram_we    = 1'b1;
              front_nxt = slot;
              occ_nxt   = occ_r + 1'b1;
            end
          end
          deqs_pkg::ACT_PUSH_BACK: begin
            if (full) begin
              res_status_nxt = deqs_pkg::STS_FULL;
            end else begin
              ram_we  = 1'b1;
              occ_nxt = occ_r + 1'b1;
            end
          end
          deqs_pkg::ACT_POP_FRONT,
          deqs_pkg::ACT_POP_BACK: begin
            if (empty) begin
              res_status_nxt = deqs_pkg::STS_EMPTY;
            end else begin
              occ_nxt = occ_r - 1'b1;
            end
          end
          default: ;
        endcase
      end
      deqs_pkg::ST_POP: begin
        // Read data of the popped slot arrives now; pop front moves the front.
        res_data_nxt = $signed(ram_rdata);
        if (act_r == deqs_pkg::ACT_POP_FRONT) begin
          front_nxt = slot;
        end
      end
      deqs_pkg::ST_SEARCH: begin
        if (idx_r != '0 && hit) begin
          res_pos_nxt = 5'(idx_r);
        end else if (idx_r >= occ_r) begin
          res_status_nxt = deqs_pkg::STS_NOT_FOUND;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      deqs_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_nxt.status   = res_status_r;
          out_nxt.data     = res_data_r;
          out_nxt.position = res_pos_r;
          out_nxt.count    = 5'(occ_r);
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deqs_pkg::ST_IDLE;
      front_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r <= in_data.action;
      key_r <= in_data.value;
    end
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_pos_r    <= res_pos_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks on the sequencer and queue bookkeeping.
  `DEQS_ASSERT_NOW(a_occ_bound, 1'b1, occ_r <= OCC_FULL, "occupancy above depth")
  `DEQS_ASSERT_NOW(a_search_idx, state_r == deqs_pkg::ST_SEARCH, idx_r <= occ_r, "search index past count")
  `DEQS_ASSERT_NEXT(a_push_grow, state_r == deqs_pkg::ST_EXEC && !full && (act_r == deqs_pkg::ACT_PUSH_FRONT || act_r == deqs_pkg::ACT_PUSH_BACK), occ_r == CW'($past(occ_r) + 1'b1), "push did not grow queue")
  `DEQS_ASSERT_NEXT(a_result_load, state_r == deqs_pkg::ST_RESULT && out_free, out_valid_r && in_ready, "result not loaded")

endmodule

/* dv/double_ended_queue_with_search_checker.sv */
// Checker that predicts and compares every result item of the double-ended queue.
module double_ended_queue_with_search_checker
  import deqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  deqs_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  deqs_out_t out_data,
  output int        fail_count,
  output int        pending,
  output int        results_seen,
  output int        full_seen,
  output int        empty_seen,
  output int        hits_seen
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Shadow copy of the queue contents and its pointers.
  logic signed [ELEM_W-1:0] shadow [DEPTH];
  logic [PTR_W-1:0]         head;
  logic [CNT_W-1:0]         fill;

  // Result items still owed by the block, oldest first.
  deqs_out_t owed_results [$];

  // Applies one input item to the shadow queue and works out its result item.
  task automatic apply_item(input deqs_in_t item, output deqs_out_t res);
    int slot;
    res = '0;
    case (item.action)
      ACT_PUSH_FRONT: begin
        if (fill == CNT_W'(DEPTH)) begin
          res.status = STS_FULL;
        end else begin
          head = (head == '0) ? PTR_W'(DEPTH - 1) : head - 1'b1;
          shadow[head] = item.value;
          fill = fill + 1'b1;
        end
      end
      ACT_PUSH_BACK: begin
        if (fill == CNT_W'(DEPTH)) begin
          res.status = STS_FULL;
        end else begin
          slot = (int'(head) + int'(fill)) % DEPTH;
          shadow[slot] = item.value;
          fill = fill + 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (fill == '0) begin
          res.status = STS_EMPTY;
        end else begin
          res.data = shadow[head];
          head = PTR_W'((int'(head) + 1) % DEPTH);
          fill = fill - 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (fill == '0) begin
          res.status = STS_EMPTY;
        end else begin
          slot = (int'(head) + int'(fill) - 1) % DEPTH;
          res.data = shadow[slot];
          fill = fill - 1'b1;
        end
      end
      ACT_SEARCH: begin
        // The first match counted from the front wins; only occupied entries are read.
        res.status = STS_NOT_FOUND;
        for (int i = 0; i < DEPTH; i++) begin
          if (i < int'(fill) && res.status == STS_NOT_FOUND &&
              shadow[(int'(head) + i) % DEPTH] == item.value) begin
            res.status   = STS_OK;
            res.position = 5'(i + 1);
          end
        end
      end
      default: ;
    endcase
    res.count = 5'(fill);
  endtask

  // Compare result items first, then record the item accepted at the same edge.
  always @(posedge clk) begin : watch
    deqs_out_t want;
    if (!rst_n) begin
      head = '0;
      fill = '0;
      owed_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          $error("result item with none expected: status %0d data %0d position %0d count %0d",
                 out_data.status, out_data.data, out_data.position, out_data.count);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, out_data.data);
            fail_count++;
          end
          if (out_data.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_data.position);
            fail_count++;
          end
          if (out_data.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_data.count);
            fail_count++;
          end
          if (want.status == STS_FULL) full_seen++;
          if (want.status == STS_EMPTY) empty_seen++;
          if (want.position != '0) hits_seen++;
        end
      end
      if (in_valid && in_ready) begin
        apply_item(in_data, want);
        owed_results.push_back(want);
      end
    end
    pending = owed_results.size();
  end

endmodule

/* dv/double_ended_queue_with_search_tb.sv */
// Testbench top that drives the double-ended queue and reports the verdict.
module double_ended_queue_with_search_tb;
  import deqs_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 1000;
  localparam int BLOCK_LEN  = 40;

  // Action codes that the block treats as no operation.
  localparam logic [2:0] ACT_SPARE_FIRST = 3'(ACT_SEARCH + 1);
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  // Traffic mix of a block of random items.
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_EVEN  = 2;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  deqs_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  deqs_out_t out_data;

  int fail_count;
  int pending;
  int results_seen;
  int full_seen;
  int empty_seen;
  int hits_seen;
  int items_sent;
  int idle_cycles;
  bit steady;

  // A few recurring keys so that searches find matches and duplicates.
  logic signed [ELEM_W-1:0] key_pool [8];

  double_ended_queue_with_search #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  double_ended_queue_with_search_checker #(
    .DEPTH(DEPTH)
  ) deque_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen),
    .full_seen   (full_seen),
    .empty_seen  (empty_seen),
    .hits_seen   (hits_seen)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long, none in steady stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Value: often a recurring key, sometimes an extreme, otherwise any pattern.
  function automatic logic signed [ELEM_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 50) return key_pool[$urandom_range(7)];
    if (r < 55) return {1'b0, {(ELEM_W - 1){1'b1}}};
    if (r < 60) return {1'b1, {(ELEM_W - 1){1'b0}}};
    return $urandom;
  endfunction

  // Action drawn from the mix of the current block.
  function automatic logic [2:0] pick_action(int mix);
    int r;
    int push_pct;
    int pop_pct;
    r        = $urandom_range(99);
    push_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 15 : 40;
    pop_pct  = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 70 : 40;
    if (r < push_pct) return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    if (r < push_pct + pop_pct) return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
    if (r < 97) return ACT_SEARCH;
    return 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
  endfunction

  // Offers one item after an optional gap and returns at the falling edge after acceptance.
  task automatic send_item(input logic [2:0] action, input logic signed [ELEM_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data.action <= action;
    in_data.value  <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Receiver: ready alternates between random holds and random stalls.
  initial begin : receiver
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // Watchdog: too many cycles in a row without any item moving ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
          $display("double_ended_queue_with_search regression: fail");
          $finish;
        end
      end
    end
  end

  // Stimulus: reset, a directed opening, then blocks of random traffic.
  initial begin : stimulus
    int mix;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    steady         = 1'b0;
    mix            = MIX_EVEN;
    foreach (key_pool[k]) key_pool[k] = $urandom;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Pops, search and spare codes on an empty queue.
    send_item(ACT_POP_FRONT, 32'sd0);
    send_item(ACT_POP_BACK, 32'sd0);
    send_item(ACT_SEARCH, 32'sd0);
    send_item(ACT_SPARE_FIRST, 32'sh7fff_ffff);
    send_item(3'(ACT_SPARE_FIRST + 1), 32'sh8000_0000);
    send_item(ACT_SPARE_LAST, -32'sd1);
    // Extremes at both ends, then searches that hit and miss.
    send_item(ACT_PUSH_FRONT, 32'sh7fff_ffff);
    send_item(ACT_PUSH_BACK, 32'sh8000_0000);
    send_item(ACT_PUSH_FRONT, 32'sd0);
    send_item(ACT_PUSH_BACK, -32'sd1);
    send_item(ACT_SEARCH, 32'sh8000_0000);
    send_item(ACT_SEARCH, -32'sd1);
    send_item(ACT_SEARCH, 32'sh1234_5678);
    send_item(ACT_SPARE_LAST, 32'sd5);
    // Drain from both ends down to the last element and past it.
    send_item(ACT_POP_FRONT, 32'sd0);
    send_item(ACT_POP_BACK, 32'sd0);
    send_item(ACT_POP_FRONT, 32'sd0);
    send_item(ACT_POP_BACK, 32'sd0);
    send_item(ACT_POP_BACK, 32'sd0);
    // Alternating bit patterns, left in place for the random part.
    send_item(ACT_PUSH_BACK, 32'shaaaa_aaaa);
    send_item(ACT_PUSH_FRONT, 32'sh5555_5555);
    send_item(ACT_SEARCH, 32'sh5555_5555);
    send_item(ACT_SEARCH, 32'shaaaa_aaaa);

    // Random traffic; each block leans toward filling, draining or neither.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % BLOCK_LEN == 0) begin
        mix    = $urandom_range(MIX_EVEN, MIX_FILL);
        steady = ($urandom_range(3) == 0);
      end
      send_item(pick_action(mix), pick_value());
    end
    in_valid <= 1'b0;
    steady   = 1'b0;

    // Let the last results drain, then give the block time for any stray output.
    wait (pending == 0);
    repeat (DEPTH + 8) @(posedge clk);

    $display("%0d input items driven, %0d result items checked", items_sent, results_seen);
    $display("%0d pushes found the queue full, %0d pops found it empty, %0d searches matched",
             full_seen, empty_seen, hits_seen);
    if (fail_count == 0) begin
      $display("double_ended_queue_with_search regression: pass");
    end else begin
      $display("double_ended_queue_with_search regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/deqs_pkg.sv
hdl/deqs_ram.sv
hdl/double_ended_queue_with_search.sv
dv/double_ended_queue_with_search_checker.sv
dv/double_ended_queue_with_search_tb.sv
